### rtl/m6502pd_pkg.sv
// Package: opcode table, mnemonic and addressing mode codes for the 6502 predecoder.
package m6502pd_pkg;

   localparam logic [5:0] MN_UNDEFINED = 6'd57;

   localparam logic [3:0] MODE_PLAIN = 4'd0;
   localparam logic [3:0] MODE_IMM   = 4'd1;
   localparam logic [3:0] MODE_X     = 4'd2;
   localparam logic [3:0] MODE_Y     = 4'd3;
   localparam logic [3:0] MODE_INDX  = 4'd4;
   localparam logic [3:0] MODE_INDY  = 4'd5;
   localparam logic [3:0] MODE_IND   = 4'd6;
   localparam logic [3:0] MODE_ACC   = 4'd7;
   localparam logic [3:0] MODE_REL   = 4'd8;

   typedef struct packed {
      logic [1:0] len;
      logic [5:0] mn;
      logic [3:0] mode;
   } op_info_type;

   function automatic op_info_type op_lookup(input logic [7:0] op);
      op_info_type e;
      e = '{len: 2'd1, mn: MN_UNDEFINED, mode: MODE_PLAIN};
      unique case (op)
         8'h00: e = '{2'd1, 6'd10, MODE_PLAIN};
         8'h01: e = '{2'd2, 6'd34, MODE_INDX};
         8'h05: e = '{2'd2, 6'd34, MODE_PLAIN};
         8'h06: e = '{2'd2, 6'd2,  MODE_PLAIN};
         8'h08: e = '{2'd1, 6'd36, MODE_PLAIN};
         8'h09: e = '{2'd2, 6'd34, MODE_IMM};
         8'h0A: e = '{2'd1, 6'd2,  MODE_ACC};
         8'h0D: e = '{2'd3, 6'd34, MODE_PLAIN};
         8'h0E: e = '{2'd3, 6'd2,  MODE_PLAIN};
         8'h10: e = '{2'd2, 6'd9,  MODE_REL};
         8'h11: e = '{2'd2, 6'd34, MODE_INDY};
         8'h15: e = '{2'd2, 6'd34, MODE_X};
         8'h16: e = '{2'd2, 6'd2,  MODE_X};
         8'h18: e = '{2'd1, 6'd13, MODE_PLAIN};
         8'h19: e = '{2'd3, 6'd34, MODE_Y};
         8'h1D: e = '{2'd3, 6'd34, MODE_X};
         8'h1E: e = '{2'd3, 6'd2,  MODE_X};
         8'h20: e = '{2'd3, 6'd28, MODE_PLAIN};
         8'h21: e = '{2'd2, 6'd1,  MODE_INDX};
         8'h24: e = '{2'd2, 6'd6,  MODE_PLAIN};
         8'h25: e = '{2'd2, 6'd1,  MODE_PLAIN};
         8'h26: e = '{2'd2, 6'd39, MODE_PLAIN};
         8'h28: e = '{2'd1, 6'd38, MODE_PLAIN};
         8'h29: e = '{2'd2, 6'd1,  MODE_IMM};
         8'h2A: e = '{2'd1, 6'd39, MODE_ACC};
         8'h2C: e = '{2'd3, 6'd6,  MODE_PLAIN};
         8'h2D: e = '{2'd3, 6'd1,  MODE_PLAIN};
         8'h2E: e = '{2'd3, 6'd39, MODE_PLAIN};
         8'h30: e = '{2'd2, 6'd7,  MODE_REL};
         8'h31: e = '{2'd2, 6'd1,  MODE_INDY};
         8'h35: e = '{2'd2, 6'd1,  MODE_X};
         8'h36: e = '{2'd2, 6'd39, MODE_X};
         8'h38: e = '{2'd1, 6'd45, MODE_PLAIN};
         8'h39: e = '{2'd3, 6'd1,  MODE_Y};
         8'h3D: e = '{2'd3, 6'd1,  MODE_X};
         8'h3E: e = '{2'd3, 6'd39, MODE_X};
         8'h40: e = '{2'd1, 6'd42, MODE_PLAIN};
         8'h41: e = '{2'd2, 6'd23, MODE_INDX};
         8'h45: e = '{2'd2, 6'd23, MODE_PLAIN};
         8'h46: e = '{2'd2, 6'd32, MODE_PLAIN};
         8'h48: e = '{2'd1, 6'd35, MODE_PLAIN};
         8'h49: e = '{2'd2, 6'd23, MODE_IMM};
         8'h4A: e = '{2'd1, 6'd32, MODE_ACC};
         8'h4C: e = '{2'd3, 6'd27, MODE_PLAIN};
         8'h4D: e = '{2'd3, 6'd23, MODE_PLAIN};
         8'h4E: e = '{2'd3, 6'd32, MODE_PLAIN};
         8'h50: e = '{2'd2, 6'd11, MODE_REL};
         8'h51: e = '{2'd2, 6'd23, MODE_INDY};
         8'h55: e = '{2'd2, 6'd23, MODE_X};
         8'h56: e = '{2'd2, 6'd32, MODE_X};
         8'h58: e = '{2'd1, 6'd15, MODE_PLAIN};
         8'h59: e = '{2'd3, 6'd23, MODE_Y};
         8'h5D: e = '{2'd3, 6'd23, MODE_X};
         8'h5E: e = '{2'd3, 6'd32, MODE_X};
         8'h60: e = '{2'd1, 6'd43, MODE_PLAIN};
         8'h61: e = '{2'd2, 6'd0,  MODE_INDX};
         8'h65: e = '{2'd2, 6'd0,  MODE_PLAIN};
         8'h66: e = '{2'd2, 6'd40, MODE_PLAIN};
         8'h68: e = '{2'd1, 6'd37, MODE_PLAIN};
         8'h69: e = '{2'd2, 6'd0,  MODE_IMM};
         8'h6A: e = '{2'd1, 6'd40, MODE_ACC};
         8'h6C: e = '{2'd3, 6'd27, MODE_IND};
         8'h6D: e = '{2'd3, 6'd0,  MODE_PLAIN};
         8'h6E: e = '{2'd3, 6'd40, MODE_PLAIN};
         8'h70: e = '{2'd2, 6'd12, MODE_REL};
         8'h71: e = '{2'd2, 6'd0,  MODE_INDY};
         8'h75: e = '{2'd2, 6'd0,  MODE_X};
         8'h76: e = '{2'd2, 6'd40, MODE_X};
         8'h78: e = '{2'd1, 6'd47, MODE_PLAIN};
         8'h79: e = '{2'd3, 6'd0,  MODE_Y};
         8'h7D: e = '{2'd3, 6'd0,  MODE_X};
         8'h7E: e = '{2'd3, 6'd40, MODE_X};
         8'h81: e = '{2'd2, 6'd48, MODE_INDX};
         8'h84: e = '{2'd2, 6'd50, MODE_PLAIN};
         8'h85: e = '{2'd2, 6'd48, MODE_PLAIN};
         8'h86: e = '{2'd2, 6'd49, MODE_PLAIN};
         8'h88: e = '{2'd1, 6'd22, MODE_PLAIN};
         8'h8A: e = '{2'd1, 6'd54, MODE_PLAIN};
         8'h8C: e = '{2'd3, 6'd50, MODE_PLAIN};
         8'h8D: e = '{2'd3, 6'd48, MODE_PLAIN};
         8'h8E: e = '{2'd3, 6'd49, MODE_PLAIN};
         8'h90: e = '{2'd2, 6'd3,  MODE_REL};
         8'h91: e = '{2'd2, 6'd48, MODE_INDY};
         8'h94: e = '{2'd2, 6'd50, MODE_X};
         8'h95: e = '{2'd2, 6'd48, MODE_X};
         8'h96: e = '{2'd2, 6'd49, MODE_Y};
         8'h98: e = '{2'd1, 6'd56, MODE_PLAIN};
         8'h99: e = '{2'd3, 6'd48, MODE_Y};
         8'h9A: e = '{2'd1, 6'd55, MODE_PLAIN};
         8'h9D: e = '{2'd3, 6'd48, MODE_X};
         8'hA0: e = '{2'd2, 6'd31, MODE_IMM};
         8'hA1: e = '{2'd2, 6'd29, MODE_INDX};
         8'hA2: e = '{2'd2, 6'd30, MODE_IMM};
         8'hA4: e = '{2'd2, 6'd31, MODE_PLAIN};
         8'hA5: e = '{2'd2, 6'd29, MODE_PLAIN};
         8'hA6: e = '{2'd2, 6'd30, MODE_PLAIN};
         8'hA8: e = '{2'd1, 6'd52, MODE_PLAIN};
         8'hA9: e = '{2'd2, 6'd29, MODE_IMM};
         8'hAA: e = '{2'd1, 6'd51, MODE_PLAIN};
         8'hAC: e = '{2'd3, 6'd31, MODE_PLAIN};
         8'hAD: e = '{2'd3, 6'd29, MODE_PLAIN};
         8'hAE: e = '{2'd3, 6'd30, MODE_PLAIN};
         8'hB0: e = '{2'd2, 6'd4,  MODE_REL};
         8'hB1: e = '{2'd2, 6'd29, MODE_INDY};
         8'hB4: e = '{2'd2, 6'd31, MODE_X};
         8'hB5: e = '{2'd2, 6'd29, MODE_X};
         8'hB6: e = '{2'd2, 6'd30, MODE_Y};
         8'hB8: e = '{2'd1, 6'd16, MODE_PLAIN};
         8'hB9: e = '{2'd3, 6'd29, MODE_Y};
         8'hBA: e = '{2'd1, 6'd53, MODE_PLAIN};
         8'hBC: e = '{2'd3, 6'd31, MODE_X};
         8'hBD: e = '{2'd3, 6'd29, MODE_X};
         8'hBE: e = '{2'd3, 6'd30, MODE_Y};
         8'hC0: e = '{2'd2, 6'd19, MODE_IMM};
         8'hC1: e = '{2'd2, 6'd17, MODE_INDX};
         8'hC4: e = '{2'd2, 6'd19, MODE_PLAIN};
         8'hC5: e = '{2'd2, 6'd17, MODE_PLAIN};
         8'hC6: e = '{2'd2, 6'd20, MODE_PLAIN};
         8'hC8: e = '{2'd1, 6'd26, MODE_PLAIN};
         8'hC9: e = '{2'd2, 6'd17, MODE_IMM};
         8'hCA: e = '{2'd1, 6'd21, MODE_PLAIN};
         8'hCC: e = '{2'd3, 6'd19, MODE_PLAIN};
         8'hCD: e = '{2'd3, 6'd17, MODE_PLAIN};
         8'hCE: e = '{2'd3, 6'd20, MODE_PLAIN};
         8'hD0: e = '{2'd2, 6'd8,  MODE_REL};
         8'hD1: e = '{2'd2, 6'd17, MODE_INDY};
         8'hD5: e = '{2'd2, 6'd17, MODE_X};
         8'hD6: e = '{2'd2, 6'd20, MODE_X};
         8'hD8: e = '{2'd1, 6'd14, MODE_PLAIN};
         8'hD9: e = '{2'd3, 6'd17, MODE_Y};
         8'hDD: e = '{2'd3, 6'd17, MODE_X};
         8'hDE: e = '{2'd3, 6'd20, MODE_X};
         8'hE0: e = '{2'd2, 6'd18, MODE_IMM};
         8'hE1: e = '{2'd2, 6'd44, MODE_INDX};
         8'hE4: e = '{2'd2, 6'd18, MODE_PLAIN};
         8'hE5: e = '{2'd2, 6'd44, MODE_PLAIN};
         8'hE6: e = '{2'd2, 6'd24, MODE_PLAIN};
         8'hE8: e = '{2'd1, 6'd25, MODE_PLAIN};
         8'hE9: e = '{2'd2, 6'd44, MODE_IMM};
         8'hEA: e = '{2'd1, 6'd33, MODE_PLAIN};
         8'hEC: e = '{2'd3, 6'd18, MODE_PLAIN};
         8'hED: e = '{2'd3, 6'd44, MODE_PLAIN};
         8'hEE: e = '{2'd3, 6'd24, MODE_PLAIN};
         8'hF0: e = '{2'd2, 6'd5,  MODE_REL};
         8'hF1: e = '{2'd2, 6'd44, MODE_INDY};
         8'hF5: e = '{2'd2, 6'd44, MODE_X};
         8'hF6: e = '{2'd2, 6'd24, MODE_X};
         8'hF8: e = '{2'd1, 6'd46, MODE_PLAIN};
         8'hF9: e = '{2'd3, 6'd44, MODE_Y};
         8'hFD: e = '{2'd3, 6'd44, MODE_X};
         8'hFE: e = '{2'd3, 6'd24, MODE_X};
         default: e = '{2'd1, MN_UNDEFINED, MODE_PLAIN};
      endcase
      return e;
   endfunction

endpackage

### rtl/mos6502_instruction_predecoder.sv
// Top level: 6502 code byte predecoder with registered input stage and result register.
//
// Accepts one code byte per cycle while req_stall is low and gives one result per
// complete instruction after its last byte passes the input and result registers. The
// opcode lookup and the 16-bit branch target add sit between those two registers. A
// csr_ write loads the origin and drops any partly received instruction; write it
// only while no byte is in flight. Throughput is set by the result register: the
// input stalls only when a finished result waits and the input register is also full.
module mos6502_instruction_predecoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_instr_address,
   output logic [7:0]  rsp_opcode_value,
   output logic [5:0]  rsp_mnemonic,
   output logic [3:0]  rsp_addr_mode,
   output logic [1:0]  rsp_instr_length,
   output logic [15:0] rsp_operand,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_start_address
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic [1:0]  remain_ff, remain_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] pc_ff, pc_in;
   logic [15:0] start_ff, start_in;
   logic        out_valid_ff;
   logic [15:0] out_addr_ff;
   logic [7:0]  out_op_ff;
   logic [5:0]  out_mn_ff;
   logic [3:0]  out_mode_ff;
   logic [1:0]  out_len_ff;
   logic [15:0] out_operand_ff;

   m6502pd_pkg::op_info_type info;
   logic [7:0]  cur_op;
   logic        first_byte;
   logic        done;
   logic        advance;
   logic        out_free;
   logic [15:0] operand_in;
   logic [15:0] offset;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   assign first_byte = (remain_ff == 2'd0);
   assign cur_op     = first_byte ? in_byte_ff : opcode_ff;
   assign info       = m6502pd_pkg::op_lookup(cur_op);
   assign offset     = {{8{in_byte_ff[7]}}, in_byte_ff};

   always_comb begin
      remain_in  = remain_ff;
      opcode_in  = opcode_ff;
      low_in     = low_ff;
      pc_in      = pc_ff;
      start_in   = start_ff;
      done       = 1'b0;
      if (first_byte) begin
         opcode_in = in_byte_ff;
         start_in  = pc_ff;
         pc_in     = pc_ff + {14'd0, info.len};
         remain_in = info.len - 2'd1;
         done      = (info.len == 2'd1);
      end else begin
         remain_in = remain_ff - 2'd1;
         done      = (remain_ff == 2'd1);
         if (remain_ff != 2'd1) begin
            low_in = in_byte_ff;
         end
      end
   end

   always_comb begin
      operand_in = 16'd0;
      if (info.len == 2'd2) begin
         if (info.mode == m6502pd_pkg::MODE_REL) begin
            operand_in = pc_ff + offset;
         end else begin
            operand_in = {8'd0, in_byte_ff};
         end
      end else if (info.len == 2'd3) begin
         operand_in = {in_byte_ff, low_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_code_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 2'd0;
         opcode_ff <= 8'd0;
         low_ff    <= 8'd0;
         pc_ff     <= 16'd0;
         start_ff  <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         remain_ff <= 2'd0;
         pc_ff     <= csr_start_address;
         start_ff  <= csr_start_address;
      end else if (advance) begin
         remain_ff <= remain_in;
         opcode_ff <= opcode_in;
         low_ff    <= low_in;
         pc_ff     <= pc_in;
         start_ff  <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && done;
      end
      if (advance && done) begin
         out_addr_ff    <= start_in;
         out_op_ff      <= opcode_in;
         out_mn_ff      <= info.mn;
         out_mode_ff    <= info.mode;
         out_len_ff     <= info.len;
         out_operand_ff <= operand_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_instr_address = out_addr_ff;
   assign rsp_opcode_value  = out_op_ff;
   assign rsp_mnemonic      = out_mn_ff;
   assign rsp_addr_mode     = out_mode_ff;
   assign rsp_instr_length  = out_len_ff;
   assign rsp_operand       = out_operand_ff;

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_instr_length != 2'd0) else $error("zero instruction length");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_operand))
      else $error("result changed under stall");
   a_remain: assert property (@(posedge clock) disable iff (reset)
      remain_ff != 2'd3) else $error("bad byte count");
   a_one_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_instr_length == 2'd1 |-> rsp_operand == 16'd0)
      else $error("operand on one-byte instruction");

endmodule

### sim/mos6502_instruction_predecoder_test.sv
// Testbench for the 6502 predecoder: directed table and random byte streams checked beat by beat.
`timescale 1ns / 100ps

module mos6502_instruction_predecoder_test;

   typedef struct packed {
      logic [1:0] len;
      logic [5:0] mn;
      logic [3:0] mode;
   } opdef_type;

   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  op;
      logic [5:0]  mn;
      logic [3:0]  mode;
      logic [1:0]  len;
      logic [15:0] operand;
   } instr_type;

   typedef struct {
      logic [7:0] code;
      bit         typed;
      instr_type  want;
   } row_type;

   localparam int LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_code_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_instr_address;
   logic [7:0]  rsp_opcode_value;
   logic [5:0]  rsp_mnemonic;
   logic [3:0]  rsp_addr_mode;
   logic [1:0]  rsp_instr_length;
   logic [15:0] rsp_operand;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_start_address;

   mos6502_instruction_predecoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_code_byte(req_code_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_instr_address(rsp_instr_address), .rsp_opcode_value(rsp_opcode_value),
      .rsp_mnemonic(rsp_mnemonic), .rsp_addr_mode(rsp_addr_mode),
      .rsp_instr_length(rsp_instr_length), .rsp_operand(rsp_operand),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_start_address(csr_start_address)
   );

   instr_type   pending_instrs[$];
   int          errors = 0;
   int          cycles = 0;
   logic [1:0]  left_bytes;
   logic [7:0]  cur_opcode;
   logic [7:0]  low_byte;
   logic [15:0] pc;
   logic [15:0] instr_pc;
   int          burst_left = 0;

   function automatic opdef_type decode_opcode(input logic [7:0] op);
      opdef_type d;
      case (op)
         8'h00: d = '{2'd1, 6'd10, m6502pd_pkg::MODE_PLAIN};
         8'h01: d = '{2'd2, 6'd34, m6502pd_pkg::MODE_INDX};
         8'h05: d = '{2'd2, 6'd34, m6502pd_pkg::MODE_PLAIN};
         8'h06: d = '{2'd2, 6'd2, m6502pd_pkg::MODE_PLAIN};
         8'h08: d = '{2'd1, 6'd36, m6502pd_pkg::MODE_PLAIN};
         8'h09: d = '{2'd2, 6'd34, m6502pd_pkg::MODE_IMM};
         8'h0A: d = '{2'd1, 6'd2, m6502pd_pkg::MODE_ACC};
         8'h0D: d = '{2'd3, 6'd34, m6502pd_pkg::MODE_PLAIN};
         8'h0E: d = '{2'd3, 6'd2, m6502pd_pkg::MODE_PLAIN};
         8'h10: d = '{2'd2, 6'd9, m6502pd_pkg::MODE_REL};
         8'h11: d = '{2'd2, 6'd34, m6502pd_pkg::MODE_INDY};
         8'h15: d = '{2'd2, 6'd34, m6502pd_pkg::MODE_X};
         8'h16: d = '{2'd2, 6'd2, m6502pd_pkg::MODE_X};
         8'h18: d = '{2'd1, 6'd13, m6502pd_pkg::MODE_PLAIN};
         8'h19: d = '{2'd3, 6'd34, m6502pd_pkg::MODE_Y};
         8'h1D: d = '{2'd3, 6'd34, m6502pd_pkg::MODE_X};
         8'h1E: d = '{2'd3, 6'd2, m6502pd_pkg::MODE_X};
         8'h20: d = '{2'd3, 6'd28, m6502pd_pkg::MODE_PLAIN};
         8'h21: d = '{2'd2, 6'd1, m6502pd_pkg::MODE_INDX};
         8'h24: d = '{2'd2, 6'd6, m6502pd_pkg::MODE_PLAIN};
         8'h25: d = '{2'd2, 6'd1, m6502pd_pkg::MODE_PLAIN};
         8'h26: d = '{2'd2, 6'd39, m6502pd_pkg::MODE_PLAIN};
         8'h28: d = '{2'd1, 6'd38, m6502pd_pkg::MODE_PLAIN};
         8'h29: d = '{2'd2, 6'd1, m6502pd_pkg::MODE_IMM};
         8'h2A: d = '{2'd1, 6'd39, m6502pd_pkg::MODE_ACC};
         8'h2C: d = '{2'd3, 6'd6, m6502pd_pkg::MODE_PLAIN};
         8'h2D: d = '{2'd3, 6'd1, m6502pd_pkg::MODE_PLAIN};
         8'h2E: d = '{2'd3, 6'd39, m6502pd_pkg::MODE_PLAIN};
         8'h30: d = '{2'd2, 6'd7, m6502pd_pkg::MODE_REL};
         8'h31: d = '{2'd2, 6'd1, m6502pd_pkg::MODE_INDY};
         8'h35: d = '{2'd2, 6'd1, m6502pd_pkg::MODE_X};
         8'h36: d = '{2'd2, 6'd39, m6502pd_pkg::MODE_X};
         8'h38: d = '{2'd1, 6'd45, m6502pd_pkg::MODE_PLAIN};
         8'h39: d = '{2'd3, 6'd1, m6502pd_pkg::MODE_Y};
         8'h3D: d = '{2'd3, 6'd1, m6502pd_pkg::MODE_X};
         8'h3E: d = '{2'd3, 6'd39, m6502pd_pkg::MODE_X};
         8'h40: d = '{2'd1, 6'd42, m6502pd_pkg::MODE_PLAIN};
         8'h41: d = '{2'd2, 6'd23, m6502pd_pkg::MODE_INDX};
         8'h45: d = '{2'd2, 6'd23, m6502pd_pkg::MODE_PLAIN};
         8'h46: d = '{2'd2, 6'd32, m6502pd_pkg::MODE_PLAIN};
         8'h48: d = '{2'd1, 6'd35, m6502pd_pkg::MODE_PLAIN};
         8'h49: d = '{2'd2, 6'd23, m6502pd_pkg::MODE_IMM};
         8'h4A: d = '{2'd1, 6'd32, m6502pd_pkg::MODE_ACC};
         8'h4C: d = '{2'd3, 6'd27, m6502pd_pkg::MODE_PLAIN};
         8'h4D: d = '{2'd3, 6'd23, m6502pd_pkg::MODE_PLAIN};
         8'h4E: d = '{2'd3, 6'd32, m6502pd_pkg::MODE_PLAIN};
         8'h50: d = '{2'd2, 6'd11, m6502pd_pkg::MODE_REL};
         8'h51: d = '{2'd2, 6'd23, m6502pd_pkg::MODE_INDY};
         8'h55: d = '{2'd2, 6'd23, m6502pd_pkg::MODE_X};
         8'h56: d = '{2'd2, 6'd32, m6502pd_pkg::MODE_X};
         8'h58: d = '{2'd1, 6'd15, m6502pd_pkg::MODE_PLAIN};
         8'h59: d = '{2'd3, 6'd23, m6502pd_pkg::MODE_Y};
         8'h5D: d = '{2'd3, 6'd23, m6502pd_pkg::MODE_X};
         8'h5E: d = '{2'd3, 6'd32, m6502pd_pkg::MODE_X};
         8'h60: d = '{2'd1, 6'd43, m6502pd_pkg::MODE_PLAIN};
         8'h61: d = '{2'd2, 6'd0, m6502pd_pkg::MODE_INDX};
         8'h65: d = '{2'd2, 6'd0, m6502pd_pkg::MODE_PLAIN};
         8'h66: d = '{2'd2, 6'd40, m6502pd_pkg::MODE_PLAIN};
         8'h68: d = '{2'd1, 6'd37, m6502pd_pkg::MODE_PLAIN};
         8'h69: d = '{2'd2, 6'd0, m6502pd_pkg::MODE_IMM};
         8'h6A: d = '{2'd1, 6'd40, m6502pd_pkg::MODE_ACC};
         8'h6C: d = '{2'd3, 6'd27, m6502pd_pkg::MODE_IND};
         8'h6D: d = '{2'd3, 6'd0, m6502pd_pkg::MODE_PLAIN};
         8'h6E: d = '{2'd3, 6'd40, m6502pd_pkg::MODE_PLAIN};
         8'h70: d = '{2'd2, 6'd12, m6502pd_pkg::MODE_REL};
         8'h71: d = '{2'd2, 6'd0, m6502pd_pkg::MODE_INDY};
         8'h75: d = '{2'd2, 6'd0, m6502pd_pkg::MODE_X};
         8'h76: d = '{2'd2, 6'd40, m6502pd_pkg::MODE_X};
         8'h78: d = '{2'd1, 6'd47, m6502pd_pkg::MODE_PLAIN};
         8'h79: d = '{2'd3, 6'd0, m6502pd_pkg::MODE_Y};
         8'h7D: d = '{2'd3, 6'd0, m6502pd_pkg::MODE_X};
         8'h7E: d = '{2'd3, 6'd40, m6502pd_pkg::MODE_X};
         8'h81: d = '{2'd2, 6'd48, m6502pd_pkg::MODE_INDX};
         8'h84: d = '{2'd2, 6'd50, m6502pd_pkg::MODE_PLAIN};
         8'h85: d = '{2'd2, 6'd48, m6502pd_pkg::MODE_PLAIN};
         8'h86: d = '{2'd2, 6'd49, m6502pd_pkg::MODE_PLAIN};
         8'h88: d = '{2'd1, 6'd22, m6502pd_pkg::MODE_PLAIN};
         8'h8A: d = '{2'd1, 6'd54, m6502pd_pkg::MODE_PLAIN};
         8'h8C: d = '{2'd3, 6'd50, m6502pd_pkg::MODE_PLAIN};
         8'h8D: d = '{2'd3, 6'd48, m6502pd_pkg::MODE_PLAIN};
         8'h8E: d = '{2'd3, 6'd49, m6502pd_pkg::MODE_PLAIN};
         8'h90: d = '{2'd2, 6'd3, m6502pd_pkg::MODE_REL};
         8'h91: d = '{2'd2, 6'd48, m6502pd_pkg::MODE_INDY};
         8'h94: d = '{2'd2, 6'd50, m6502pd_pkg::MODE_X};
         8'h95: d = '{2'd2, 6'd48, m6502pd_pkg::MODE_X};
         8'h96: d = '{2'd2, 6'd49, m6502pd_pkg::MODE_Y};
         8'h98: d = '{2'd1, 6'd56, m6502pd_pkg::MODE_PLAIN};
         8'h99: d = '{2'd3, 6'd48, m6502pd_pkg::MODE_Y};
         8'h9A: d = '{2'd1, 6'd55, m6502pd_pkg::MODE_PLAIN};
         8'h9D: d = '{2'd3, 6'd48, m6502pd_pkg::MODE_X};
         8'hA0: d = '{2'd2, 6'd31, m6502pd_pkg::MODE_IMM};
         8'hA1: d = '{2'd2, 6'd29, m6502pd_pkg::MODE_INDX};
         8'hA2: d = '{2'd2, 6'd30, m6502pd_pkg::MODE_IMM};
         8'hA4: d = '{2'd2, 6'd31, m6502pd_pkg::MODE_PLAIN};
         8'hA5: d = '{2'd2, 6'd29, m6502pd_pkg::MODE_PLAIN};
         8'hA6: d = '{2'd2, 6'd30, m6502pd_pkg::MODE_PLAIN};
         8'hA8: d = '{2'd1, 6'd52, m6502pd_pkg::MODE_PLAIN};
         8'hA9: d = '{2'd2, 6'd29, m6502pd_pkg::MODE_IMM};
         8'hAA: d = '{2'd1, 6'd51, m6502pd_pkg::MODE_PLAIN};
         8'hAC: d = '{2'd3, 6'd31, m6502pd_pkg::MODE_PLAIN};
         8'hAD: d = '{2'd3, 6'd29, m6502pd_pkg::MODE_PLAIN};
         8'hAE: d = '{2'd3, 6'd30, m6502pd_pkg::MODE_PLAIN};
         8'hB0: d = '{2'd2, 6'd4, m6502pd_pkg::MODE_REL};
         8'hB1: d = '{2'd2, 6'd29, m6502pd_pkg::MODE_INDY};
         8'hB4: d = '{2'd2, 6'd31, m6502pd_pkg::MODE_X};
         8'hB5: d = '{2'd2, 6'd29, m6502pd_pkg::MODE_X};
         8'hB6: d = '{2'd2, 6'd30, m6502pd_pkg::MODE_Y};
         8'hB8: d = '{2'd1, 6'd16, m6502pd_pkg::MODE_PLAIN};
         8'hB9: d = '{2'd3, 6'd29, m6502pd_pkg::MODE_Y};
         8'hBA: d = '{2'd1, 6'd53, m6502pd_pkg::MODE_PLAIN};
         8'hBC: d = '{2'd3, 6'd31, m6502pd_pkg::MODE_X};
         8'hBD: d = '{2'd3, 6'd29, m6502pd_pkg::MODE_X};
         8'hBE: d = '{2'd3, 6'd30, m6502pd_pkg::MODE_Y};
         8'hC0: d = '{2'd2, 6'd19, m6502pd_pkg::MODE_IMM};
         8'hC1: d = '{2'd2, 6'd17, m6502pd_pkg::MODE_INDX};
         8'hC4: d = '{2'd2, 6'd19, m6502pd_pkg::MODE_PLAIN};
         8'hC5: d = '{2'd2, 6'd17, m6502pd_pkg::MODE_PLAIN};
         8'hC6: d = '{2'd2, 6'd20, m6502pd_pkg::MODE_PLAIN};
         8'hC8: d = '{2'd1, 6'd26, m6502pd_pkg::MODE_PLAIN};
         8'hC9: d = '{2'd2, 6'd17, m6502pd_pkg::MODE_IMM};
         8'hCA: d = '{2'd1, 6'd21, m6502pd_pkg::MODE_PLAIN};
         8'hCC: d = '{2'd3, 6'd19, m6502pd_pkg::MODE_PLAIN};
         8'hCD: d = '{2'd3, 6'd17, m6502pd_pkg::MODE_PLAIN};
         8'hCE: d = '{2'd3, 6'd20, m6502pd_pkg::MODE_PLAIN};
         8'hD0: d = '{2'd2, 6'd8, m6502pd_pkg::MODE_REL};
         8'hD1: d = '{2'd2, 6'd17, m6502pd_pkg::MODE_INDY};
         8'hD5: d = '{2'd2, 6'd17, m6502pd_pkg::MODE_X};
         8'hD6: d = '{2'd2, 6'd20, m6502pd_pkg::MODE_X};
         8'hD8: d = '{2'd1, 6'd14, m6502pd_pkg::MODE_PLAIN};
         8'hD9: d = '{2'd3, 6'd17, m6502pd_pkg::MODE_Y};
         8'hDD: d = '{2'd3, 6'd17, m6502pd_pkg::MODE_X};
         8'hDE: d = '{2'd3, 6'd20, m6502pd_pkg::MODE_X};
         8'hE0: d = '{2'd2, 6'd18, m6502pd_pkg::MODE_IMM};
         8'hE1: d = '{2'd2, 6'd44, m6502pd_pkg::MODE_INDX};
         8'hE4: d = '{2'd2, 6'd18, m6502pd_pkg::MODE_PLAIN};
         8'hE5: d = '{2'd2, 6'd44, m6502pd_pkg::MODE_PLAIN};
         8'hE6: d = '{2'd2, 6'd24, m6502pd_pkg::MODE_PLAIN};
         8'hE8: d = '{2'd1, 6'd25, m6502pd_pkg::MODE_PLAIN};
         8'hE9: d = '{2'd2, 6'd44, m6502pd_pkg::MODE_IMM};
         8'hEA: d = '{2'd1, 6'd33, m6502pd_pkg::MODE_PLAIN};
         8'hEC: d = '{2'd3, 6'd18, m6502pd_pkg::MODE_PLAIN};
         8'hED: d = '{2'd3, 6'd44, m6502pd_pkg::MODE_PLAIN};
         8'hEE: d = '{2'd3, 6'd24, m6502pd_pkg::MODE_PLAIN};
         8'hF0: d = '{2'd2, 6'd5, m6502pd_pkg::MODE_REL};
         8'hF1: d = '{2'd2, 6'd44, m6502pd_pkg::MODE_INDY};
         8'hF5: d = '{2'd2, 6'd44, m6502pd_pkg::MODE_X};
         8'hF6: d = '{2'd2, 6'd24, m6502pd_pkg::MODE_X};
         8'hF8: d = '{2'd1, 6'd46, m6502pd_pkg::MODE_PLAIN};
         8'hF9: d = '{2'd3, 6'd44, m6502pd_pkg::MODE_Y};
         8'hFD: d = '{2'd3, 6'd44, m6502pd_pkg::MODE_X};
         8'hFE: d = '{2'd3, 6'd24, m6502pd_pkg::MODE_X};
         default: d = '{2'd1, m6502pd_pkg::MN_UNDEFINED, m6502pd_pkg::MODE_PLAIN};
      endcase
      return d;
   endfunction

   // advance the decoder copy by one byte; done is set when an instruction completes
   task automatic decode_byte(input logic [7:0] b, output bit done, output instr_type r);
      opdef_type d;
      logic [15:0] offs;
      done = 0;
      r = '0;
      if (left_bytes == 2'd0) begin
         d = decode_opcode(b);
         cur_opcode = b;
         instr_pc = pc;
         pc = pc + {14'd0, d.len};
         left_bytes = d.len - 2'd1;
      end else begin
         d = decode_opcode(cur_opcode);
         left_bytes = left_bytes - 2'd1;
         if (left_bytes != 2'd0) begin
            low_byte = b;
            return;
         end
      end
      if (left_bytes != 2'd0) return;
      done = 1;
      r.addr = instr_pc;
      r.op = cur_opcode;
      r.mn = d.mn;
      r.mode = d.mode;
      r.len = d.len;
      if (d.len == 2'd2) begin
         offs = {{8{b[7]}}, b};
         r.operand = (d.mode == m6502pd_pkg::MODE_REL) ? pc + offs : {8'h00, b};
      end else if (d.len == 2'd3) begin
         r.operand = {b, low_byte};
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed, input instr_type want);
      bit done;
      instr_type r;
      req_valid <= 1'b1;
      req_code_byte <= b;
      do @(posedge clock); while (req_stall);
      decode_byte(b, done, r);
      if (done) pending_instrs.push_back(typed ? want : r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_instrs.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_origin(input logic [15:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_start_address <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pc = v;
      instr_pc = v;
      left_bytes = 2'd0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // check result beats and drive the stall pattern
   always @(posedge clock) begin
      instr_type got;
      instr_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_instr_address, rsp_opcode_value, rsp_mnemonic, rsp_addr_mode,
                    rsp_instr_length, rsp_operand};
            if (pending_instrs.size() == 0) begin
               $display("%0t: unexpected beat, actual %h", $time, got);
               errors++;
            end else begin
               want = pending_instrs.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected addr %h op %h mn %0d mode %0d len %0d opnd %h",
                           $time, want.addr, want.op, want.mn, want.mode, want.len,
                           want.operand);
                  $display("%0t:          actual   addr %h op %h mn %0d mode %0d len %0d opnd %h",
                           $time, got.addr, got.op, got.mn, got.mode, got.len, got.operand);
                  errors++;
               end
            end
         end
         case ((cycles / 97) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            2: rsp_stall <= ((cycles % 11) < 7);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   initial begin
      row_type table_rows[$];
      instr_type none;
      logic [15:0] origins[$];
      int n;
      none = '0;
      table_rows = '{
         '{8'h00, 1, '{16'h0000, 8'h00, 6'd10, m6502pd_pkg::MODE_PLAIN, 2'd1, 16'h0000}},
         '{8'hFF, 1, '{16'h0001, 8'hFF, m6502pd_pkg::MN_UNDEFINED, m6502pd_pkg::MODE_PLAIN,
                       2'd1, 16'h0000}},
         '{8'h6A, 1, '{16'h0002, 8'h6A, 6'd40, m6502pd_pkg::MODE_ACC, 2'd1, 16'h0000}},
         '{8'hA9, 0, none}, '{8'h00, 0, none},
         '{8'hA9, 0, none}, '{8'hFF, 0, none},
         '{8'hAD, 0, none}, '{8'h34, 0, none}, '{8'h12, 0, none},
         '{8'h4C, 0, none}, '{8'hFF, 0, none}, '{8'hFF, 0, none},
         '{8'h6C, 0, none}, '{8'h00, 0, none}, '{8'h00, 0, none},
         '{8'h10, 0, none}, '{8'h80, 0, none},
         '{8'hD0, 0, none}, '{8'h7F, 0, none},
         '{8'hB1, 0, none}, '{8'h55, 0, none},
         '{8'h02, 0, none}, '{8'hBE, 0, none}, '{8'hAA, 0, none}
      };
      reset = 1'b1;
      req_valid = 1'b0;
      req_code_byte = 8'h00;
      csr_valid = 1'b0;
      csr_start_address = 16'h0000;
      pc = 0;
      instr_pc = 0;
      left_bytes = 0;
      cur_opcode = 0;
      low_byte = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) send_byte(table_rows[i].code, table_rows[i].typed,
                                        table_rows[i].want);
      // wrap the program counter and a forward branch past the top of memory
      write_origin(16'hFFFE);
      send_byte(8'hF0, 0, none);
      send_byte(8'h7F, 0, none);
      send_byte(8'hEA, 0, none);
      // drop a half-received instruction
      send_byte(8'h8D, 0, none);
      send_byte(8'h11, 0, none);

      origins = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
      repeat (4) origins.push_back(16'($urandom_range(0, 16'hFFFF)));
      foreach (origins[p]) begin
         write_origin(origins[p]);
         n = 65 + $urandom_range(0, 6);
         for (int k = 0; k < n; k++) begin
            if (p == 2 && k == 30) begin
               req_valid <= 1'b0;
               while (pending_instrs.size() != 0) @(posedge clock);
            end
            send_byte(8'($urandom_range(0, 255)), 0, none);
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
